FILE: design/lls_pkg.sv
// types, constants and rounding helpers for the lagrange line shape function block
// no dependencies
`timescale 1ns / 1ps

package lls_pkg;

   localparam int COORD_W = 16;
   localparam int FAC_W   = 18;
   localparam int PROD_W  = 36;
   localparam int SUM_W   = 40;
   localparam int NUM_W   = 56;
   localparam int FIELD_W = 18;

   typedef logic        [1:0]         order_type;
   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [FAC_W-1:0]   fac_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic signed [NUM_W-1:0]   num_type;
   typedef logic signed [FIELD_W-1:0] field_type;

   localparam order_type ORDER_NONE   = 2'd0;
   localparam order_type ORDER_LINEAR = 2'd1;
   localparam order_type ORDER_QUAD   = 2'd2;
   localparam order_type ORDER_CUBIC  = 2'd3;

   localparam coord_type ONE_COORD  = 16'sd16384;
   localparam coord_type MONE_COORD = -16'sd16384;
   localparam fac_type   ONE_FAC    = 18'sd16384;
   localparam num_type   ONE_NUM    = 56'sd16384;
   localparam field_type HALF_FIELD = 18'sd8192;
   localparam num_type   FIELD_MAX  = 56'sd131071;
   localparam num_type   FIELD_MIN  = -56'sd131072;

   localparam int SHIFT_LIN   = 1;
   localparam int SHIFT_QUAD  = 15;
   localparam int SHIFT_MID   = 14;
   localparam int SHIFT_CUBIC = 32;
   localparam int SHIFT_SLOPE = 18;

   // round to nearest, ties toward plus infinity
   function automatic num_type round_shift(input num_type v, input int k);
      num_type half;
      half = num_type'(1) <<< (k - 1);
      return (v + half) >>> k;
   endfunction

   function automatic field_type sat_field(input num_type v);
      field_type r;
      if (v > FIELD_MAX) begin
         r = field_type'(FIELD_MAX);
      end else if (v < FIELD_MIN) begin
         r = field_type'(FIELD_MIN);
      end else begin
         r = v[FIELD_W-1:0];
      end
      return r;
   endfunction

   function automatic sum_type times3(input sum_type v);
      return (v <<< 1) + v;
   endfunction

   function automatic num_type times9(input num_type v);
      return (v <<< 3) + v;
   endfunction

endpackage

FILE: design/lagrange_line_shape_functions.sv
// lagrange line shape functions, orders 1 to 3: five-stage stalling pipeline
// a request accepted into stage 1 moves on through stages 2 to 5 in order; rsp_valid is the stage 5 valid bit
// throughput: one request per cycle; each stage holds only while the next one is full and stalled
// reset: synchronous, active high; clears all stage valid bits and sets the order to linear
// depends on lls_pkg
`timescale 1ns / 1ps

module lagrange_line_shape_functions
   import lls_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_valid,
   output logic      csr_ready,
   input  order_type csr_element_order,
   input  logic      req_valid,
   output logic      req_ready,
   input  coord_type req_coordinate,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output field_type rsp_basis_zero,
   output field_type rsp_basis_one,
   output field_type rsp_basis_two,
   output field_type rsp_basis_three,
   output field_type rsp_slope_zero,
   output field_type rsp_slope_one,
   output field_type rsp_slope_two,
   output field_type rsp_slope_three
);

   localparam int NSTAGE = 5;

   order_type            order_ff;
   logic [NSTAGE-1:0]    valid_ff;
   logic [NSTAGE-1:0]    valid_in;
   logic [NSTAGE-1:0]    en;

   // stage 1
   coord_type x1_ff, x1_in;
   order_type o1_ff;
   // stage 2
   coord_type x2_ff;
   order_type o2_ff;
   fac_type   p2_ff, m2_ff, tp2_ff, tm2_ff;
   fac_type   p2_in, m2_in, tp2_in, tm2_in, x2_ext;
   // stage 3
   coord_type x3_ff;
   order_type o3_ff;
   fac_type   p3_ff, m3_ff;
   prod_type  tptm3_ff, tmm3_ff, tpm3_ff, ptm3_ff, ptp3_ff, pm3_ff, xm3_ff, xp3_ff;
   // stage 4
   coord_type x4_ff;
   order_type o4_ff;
   prod_type  pm4_ff, xm4_ff, xp4_ff;
   num_type   nb0_4_ff, nb1_4_ff, nb2_4_ff, nb3_4_ff;
   sum_type   nd0_4_ff, nd1_4_ff, nd2_4_ff, nd3_4_ff;
   num_type   nb0_4_in, nb1_4_in, nb2_4_in, nb3_4_in;
   sum_type   nd0_4_in, nd1_4_in, nd2_4_in, nd3_4_in;
   // stage 5
   order_type o5_ff;
   field_type b0_ff, b1_ff, b2_ff, b3_ff, d0_ff, d1_ff, d2_ff, d3_ff;
   field_type b0_in, b1_in, b2_in, b3_in, d0_in, d1_in, d2_in, d3_in;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_LINEAR;
      end else if (csr_valid) begin
         order_ff <= csr_element_order;
      end
   end

   // flow control
   always_comb begin
      en[NSTAGE-1] = !valid_ff[NSTAGE-1] || rsp_ready;
      for (int i = NSTAGE - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      valid_in[0] = req_valid;
      for (int i = 1; i < NSTAGE; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NSTAGE; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   assign req_ready = en[0];

   // stage 1: saturate the coordinate
   always_comb begin
      if (req_coordinate > ONE_COORD) begin
         x1_in = ONE_COORD;
      end else if (req_coordinate < MONE_COORD) begin
         x1_in = MONE_COORD;
      end else begin
         x1_in = req_coordinate;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x1_ff <= x1_in;
         o1_ff <= order_ff;
      end
   end

   // stage 2: node factors
   always_comb begin
      x2_ext = fac_type'(x1_ff);
      p2_in  = x2_ext + ONE_FAC;
      m2_in  = x2_ext - ONE_FAC;
      tp2_in = (x2_ext <<< 1) + x2_ext + ONE_FAC;
      tm2_in = (x2_ext <<< 1) + x2_ext - ONE_FAC;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         x2_ff  <= x1_ff;
         o2_ff  <= o1_ff;
         p2_ff  <= p2_in;
         m2_ff  <= m2_in;
         tp2_ff <= tp2_in;
         tm2_ff <= tm2_in;
      end
   end

   // stage 3: pairwise products
   always_ff @(posedge clock) begin
      if (en[2]) begin
         x3_ff    <= x2_ff;
         o3_ff    <= o2_ff;
         p3_ff    <= p2_ff;
         m3_ff    <= m2_ff;
         tptm3_ff <= prod_type'(tp2_ff) * prod_type'(tm2_ff);
         tmm3_ff  <= prod_type'(tm2_ff) * prod_type'(m2_ff);
         tpm3_ff  <= prod_type'(tp2_ff) * prod_type'(m2_ff);
         ptm3_ff  <= prod_type'(p2_ff) * prod_type'(tm2_ff);
         ptp3_ff  <= prod_type'(p2_ff) * prod_type'(tp2_ff);
         pm3_ff   <= prod_type'(p2_ff) * prod_type'(m2_ff);
         xm3_ff   <= prod_type'(x2_ff) * prod_type'(m2_ff);
         xp3_ff   <= prod_type'(x2_ff) * prod_type'(p2_ff);
      end
   end

   // stage 4: cubic numerators and slope sums
   always_comb begin
      nb0_4_in = -(num_type'(tptm3_ff) * num_type'(m3_ff));
      nb1_4_in = num_type'(tptm3_ff) * num_type'(p3_ff);
      nb2_4_in = num_type'(ptm3_ff) * num_type'(m3_ff);
      nb3_4_in = -(num_type'(ptp3_ff) * num_type'(m3_ff));
      nd0_4_in = -(times3(sum_type'(tmm3_ff)) + times3(sum_type'(tpm3_ff))
                   + sum_type'(tptm3_ff));
      nd1_4_in = sum_type'(tptm3_ff) + times3(sum_type'(ptm3_ff))
                 + times3(sum_type'(ptp3_ff));
      nd2_4_in = sum_type'(tmm3_ff) + times3(sum_type'(pm3_ff)) + sum_type'(ptm3_ff);
      nd3_4_in = -(sum_type'(tpm3_ff) + times3(sum_type'(pm3_ff)) + sum_type'(ptp3_ff));
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         x4_ff    <= x3_ff;
         o4_ff    <= o3_ff;
         pm4_ff   <= pm3_ff;
         xm4_ff   <= xm3_ff;
         xp4_ff   <= xp3_ff;
         nb0_4_ff <= nb0_4_in;
         nb1_4_ff <= nb1_4_in;
         nb2_4_ff <= nb2_4_in;
         nb3_4_ff <= nb3_4_in;
         nd0_4_ff <= nd0_4_in;
         nd1_4_ff <= nd1_4_in;
         nd2_4_ff <= nd2_4_in;
         nd3_4_ff <= nd3_4_in;
      end
   end

   // stage 5: scale, round, select by order, saturate
   always_comb begin
      num_type xn;
      xn    = num_type'(x4_ff);
      b0_in = '0;
      b1_in = '0;
      b2_in = '0;
      b3_in = '0;
      d0_in = '0;
      d1_in = '0;
      d2_in = '0;
      d3_in = '0;
      case (o4_ff)
         ORDER_LINEAR: begin
            b0_in = sat_field(round_shift(ONE_NUM - xn, SHIFT_LIN));
            b1_in = sat_field(round_shift(ONE_NUM + xn, SHIFT_LIN));
            d0_in = -HALF_FIELD;
            d1_in = HALF_FIELD;
         end
         ORDER_QUAD: begin
            b0_in = sat_field(round_shift(num_type'(xm4_ff), SHIFT_QUAD));
            b1_in = sat_field(round_shift(num_type'(xp4_ff), SHIFT_QUAD));
            b2_in = sat_field(round_shift(-num_type'(pm4_ff), SHIFT_MID));
            d0_in = field_type'(x4_ff) - HALF_FIELD;
            d1_in = field_type'(x4_ff) + HALF_FIELD;
            d2_in = -(field_type'(x4_ff) <<< 1);
         end
         ORDER_CUBIC: begin
            b0_in = sat_field(round_shift(nb0_4_ff, SHIFT_CUBIC));
            b1_in = sat_field(round_shift(nb1_4_ff, SHIFT_CUBIC));
            b2_in = sat_field(round_shift(times9(nb2_4_ff), SHIFT_CUBIC));
            b3_in = sat_field(round_shift(times9(nb3_4_ff), SHIFT_CUBIC));
            d0_in = sat_field(round_shift(num_type'(nd0_4_ff), SHIFT_SLOPE));
            d1_in = sat_field(round_shift(num_type'(nd1_4_ff), SHIFT_SLOPE));
            d2_in = sat_field(round_shift(times9(num_type'(nd2_4_ff)), SHIFT_SLOPE));
            d3_in = sat_field(round_shift(times9(num_type'(nd3_4_ff)), SHIFT_SLOPE));
         end
         default: begin
            b0_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         o5_ff <= o4_ff;
         b0_ff <= b0_in;
         b1_ff <= b1_in;
         b2_ff <= b2_in;
         b3_ff <= b3_in;
         d0_ff <= d0_in;
         d1_ff <= d1_in;
         d2_ff <= d2_in;
         d3_ff <= d3_in;
      end
   end

   assign rsp_valid       = valid_ff[NSTAGE-1];
   assign rsp_basis_zero  = b0_ff;
   assign rsp_basis_one   = b1_ff;
   assign rsp_basis_two   = b2_ff;
   assign rsp_basis_three = b3_ff;
   assign rsp_slope_zero  = d0_ff;
   assign rsp_slope_one   = d1_ff;
   assign rsp_slope_two   = d2_ff;
   assign rsp_slope_three = d3_ff;

   // checks
   logic signed [FIELD_W+1:0] basis_sum, slope_sum;

   assign basis_sum = (FIELD_W+2)'(b0_ff) + (FIELD_W+2)'(b1_ff)
                      + (FIELD_W+2)'(b2_ff) + (FIELD_W+2)'(b3_ff);
   assign slope_sum = (FIELD_W+2)'(d0_ff) + (FIELD_W+2)'(d1_ff)
                      + (FIELD_W+2)'(d2_ff) + (FIELD_W+2)'(d3_ff);

   // partition of unity, within the rounding of four terms
   a_basis_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && o5_ff != ORDER_NONE |->
         basis_sum >= 20'sd16382 && basis_sum <= 20'sd16386)
      else $error("basis values do not sum to one");

   a_slope_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && o5_ff != ORDER_NONE |->
         slope_sum >= -20'sd2 && slope_sum <= 20'sd2)
      else $error("slopes do not sum to zero");

   a_unused_slots: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && o5_ff != ORDER_CUBIC |->
         b3_ff == '0 && d3_ff == '0 && (o5_ff != ORDER_LINEAR || (b2_ff == '0 && d2_ff == '0)))
      else $error("unused node slot not zero");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      &valid_ff && !rsp_ready |-> !req_ready)
      else $error("request taken while pipeline full and stalled");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(o5_ff) && $stable(b0_ff))
      else $error("stalled result changed");

endmodule

FILE: bench/lls_shape_checker.sv
// checker for the lagrange line shape function block: watches the csr, request and
// response channels, predicts every response and compares it field by field
// depends on lls_pkg
`timescale 1ns / 1ps

module lls_shape_checker
   import lls_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_valid,
   input  logic      csr_ready,
   input  order_type csr_element_order,
   input  logic      req_valid,
   input  logic      req_ready,
   input  coord_type req_coordinate,
   input  logic      rsp_valid,
   input  logic      rsp_ready,
   input  field_type rsp_basis_zero,
   input  field_type rsp_basis_one,
   input  field_type rsp_basis_two,
   input  field_type rsp_basis_three,
   input  field_type rsp_slope_zero,
   input  field_type rsp_slope_one,
   input  field_type rsp_slope_two,
   input  field_type rsp_slope_three,
   output int        mismatch_count,
   output int        pending_count
);

   // basis values in slots 0 to 3, slopes in slots 4 to 7
   typedef logic [7:0][FIELD_W-1:0] shape_word;

   shape_word expected_shapes[$];
   order_type shadow_order = ORDER_LINEAR;
   int        response_index = 0;

   function automatic longint round_q14(input longint v, input int k);
      return (v + (longint'(1) <<< (k - 1))) >>> k;
   endfunction

   function automatic logic [FIELD_W-1:0] clip_field(input longint v);
      longint c;
      c = v;
      if (c > 131071) begin
         c = 131071;
      end else if (c < -131072) begin
         c = -131072;
      end
      return c[FIELD_W-1:0];
   endfunction

   function automatic shape_word evaluate_shapes(input order_type ord, input coord_type coord);
      longint    s;
      longint    x;
      longint    p;
      longint    m;
      longint    tp;
      longint    tm;
      longint    b[4];
      longint    d[4];
      shape_word w;
      s = 16384;
      x = longint'(coord);
      if (x > s) begin
         x = s;
      end
      if (x < -s) begin
         x = -s;
      end
      for (int i = 0; i < 4; i++) begin
         b[i] = 0;
         d[i] = 0;
      end
      case (ord)
         ORDER_LINEAR: begin
            b[0] = round_q14(s - x, 1);
            b[1] = round_q14(s + x, 1);
            d[0] = -(s / 2);
            d[1] = s / 2;
         end
         ORDER_QUAD: begin
            b[0] = round_q14(x * (x - s), 15);
            b[1] = round_q14(x * (x + s), 15);
            b[2] = round_q14((s + x) * (s - x), 14);
            d[0] = x - s / 2;
            d[1] = x + s / 2;
            d[2] = -2 * x;
         end
         ORDER_CUBIC: begin
            p  = x + s;
            m  = x - s;
            tp = 3 * x + s;
            tm = 3 * x - s;
            b[0] = round_q14(-(tp * tm * m), 32);
            b[1] = round_q14(p * tp * tm, 32);
            b[2] = round_q14(9 * p * tm * m, 32);
            b[3] = round_q14(-9 * p * tp * m, 32);
            d[0] = round_q14(-(3 * tm * m + 3 * tp * m + tp * tm), 18);
            d[1] = round_q14(tp * tm + 3 * p * tm + 3 * p * tp, 18);
            d[2] = round_q14(9 * (tm * m + 3 * p * m + p * tm), 18);
            d[3] = round_q14(-9 * (tp * m + 3 * p * m + p * tp), 18);
         end
         default: begin
         end
      endcase
      for (int i = 0; i < 4; i++) begin
         w[i]     = clip_field(b[i]);
         w[4 + i] = clip_field(d[i]);
      end
      return w;
   endfunction

   function automatic string field_label(input int i);
      case (i)
         0: return "basis_zero";
         1: return "basis_one";
         2: return "basis_two";
         3: return "basis_three";
         4: return "slope_zero";
         5: return "slope_one";
         6: return "slope_two";
         default: return "slope_three";
      endcase
   endfunction

   always @(posedge clock) begin : watch
      shape_word seen;
      shape_word want;
      if (reset) begin
         shadow_order = ORDER_LINEAR;
         mismatch_count = 0;
         expected_shapes.delete();
      end else begin
         // a request taken at the same edge as a csr write still sees the old order
         if (req_valid && req_ready) begin
            expected_shapes.push_back(evaluate_shapes(shadow_order, req_coordinate));
         end
         if (csr_valid && csr_ready) begin
            shadow_order = csr_element_order;
         end
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_slope_three, rsp_slope_two, rsp_slope_one, rsp_slope_zero,
                    rsp_basis_three, rsp_basis_two, rsp_basis_one, rsp_basis_zero};
            if (expected_shapes.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("response %0d arrived with no request outstanding", response_index);
               end
               mismatch_count = mismatch_count + 1;
            end else begin
               want = expected_shapes.pop_front();
               for (int i = 0; i < 8; i++) begin
                  if (seen[i] !== want[i]) begin
                     if (mismatch_count < 10) begin
                        $display("response %0d %s: expected %0d, got %0d", response_index,
                                 field_label(i), $signed(want[i]), $signed(seen[i]));
                     end
                     mismatch_count = mismatch_count + 1;
                  end
               end
            end
            response_index = response_index + 1;
         end
      end
      pending_count = expected_shapes.size();
   end

endmodule

FILE: bench/lagrange_line_shape_functions_tb.sv
// top of the lagrange line shape function testbench: clock, reset, csr writes and
// coordinate requests under random idling; verdict taken from lls_shape_checker
// depends on lls_pkg, lls_shape_checker and lagrange_line_shape_functions
`timescale 1ns / 1ps

module lagrange_line_shape_functions_tb;
   import lls_pkg::*;

   logic      clock             = 1'b0;
   logic      reset             = 1'b1;
   logic      csr_valid         = 1'b0;
   order_type csr_element_order = ORDER_LINEAR;
   logic      req_valid         = 1'b0;
   coord_type req_coordinate    = '0;
   logic      rsp_ready         = 1'b0;

   logic      csr_ready;
   logic      req_ready;
   logic      rsp_valid;
   field_type rsp_basis_zero;
   field_type rsp_basis_one;
   field_type rsp_basis_two;
   field_type rsp_basis_three;
   field_type rsp_slope_zero;
   field_type rsp_slope_one;
   field_type rsp_slope_two;
   field_type rsp_slope_three;

   int mismatch_count;
   int pending_count;
   int calm_requests = 0;
   int stall_left    = 0;
   int steady_left   = 0;

   lagrange_line_shape_functions i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_element_order (csr_element_order),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_coordinate    (req_coordinate),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_basis_zero    (rsp_basis_zero),
      .rsp_basis_one     (rsp_basis_one),
      .rsp_basis_two     (rsp_basis_two),
      .rsp_basis_three   (rsp_basis_three),
      .rsp_slope_zero    (rsp_slope_zero),
      .rsp_slope_one     (rsp_slope_one),
      .rsp_slope_two     (rsp_slope_two),
      .rsp_slope_three   (rsp_slope_three)
   );

   lls_shape_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_element_order (csr_element_order),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_coordinate    (req_coordinate),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_basis_zero    (rsp_basis_zero),
      .rsp_basis_one     (rsp_basis_one),
      .rsp_basis_two     (rsp_basis_two),
      .rsp_basis_three   (rsp_basis_three),
      .rsp_slope_zero    (rsp_slope_zero),
      .rsp_slope_one     (rsp_slope_one),
      .rsp_slope_two     (rsp_slope_two),
      .rsp_slope_three   (rsp_slope_three),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #12_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // response backpressure: short stalls, a few long ones, and stretches of steady ready
   always @(posedge clock) begin : backpressure
      int roll;
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (steady_left > 0) begin
         steady_left = steady_left - 1;
         rsp_ready <= 1'b1;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            steady_left = $urandom_range(20, 100);
            rsp_ready <= 1'b1;
         end else if (roll < 8) begin
            stall_left = $urandom_range(10, 40);
            rsp_ready <= 1'b0;
         end else if (roll < 35) begin
            stall_left = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic coord_type pick_coordinate();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         return coord_type'(int'($urandom_range(0, 32768)) - 16384);
      end else if (roll < 85) begin
         return coord_type'($urandom);
      end else if (roll < 95) begin
         case ($urandom_range(0, 14))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return -16'sd16385;
            3:       return MONE_COORD;
            4:       return -16'sd16383;
            5:       return -16'sd1;
            6:       return 16'sd0;
            7:       return 16'sd1;
            8:       return 16'sd16383;
            9:       return ONE_COORD;
            10:      return 16'sd16385;
            11:      return 16'sd5461;
            12:      return 16'sd5462;
            13:      return -16'sd5461;
            default: return -16'sd5462;
         endcase
      end else if ($urandom_range(0, 1) == 0) begin
         return coord_type'(16384 + int'($urandom_range(0, 8)) - 4);
      end else begin
         return coord_type'(-16384 + int'($urandom_range(0, 8)) - 4);
      end
   endfunction

   task automatic send_request(input coord_type coord);
      int gap;
      int roll;
      gap = 0;
      if (calm_requests > 0) begin
         calm_requests = calm_requests - 1;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            calm_requests = $urandom_range(20, 80);
         end else if (roll < 6) begin
            gap = $urandom_range(20, 60);
         end else if (roll < 18) begin
            gap = $urandom_range(4, 10);
         end else if (roll < 60) begin
            gap = $urandom_range(1, 3);
         end
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_coordinate <= coord;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_order(input order_type ord);
      wait_drained();
      csr_valid         <= 1'b1;
      csr_element_order <= ord;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      order_type plan [0:7];
      coord_type corners [0:5];
      plan    = '{ORDER_LINEAR, ORDER_CUBIC, ORDER_QUAD, ORDER_NONE,
                  ORDER_LINEAR, ORDER_CUBIC, ORDER_QUAD, ORDER_CUBIC};
      corners = '{16'sh8000, 16'sh7FFF, MONE_COORD, ONE_COORD, -16'sd5461, 16'sd5461};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int phase = 0; phase < 8; phase++) begin
         // first phase runs on the order left by reset
         if (phase > 0) begin
            write_order(plan[phase]);
         end
         if (phase < 4) begin
            for (int i = 0; i < 6; i++) begin
               send_request(corners[i]);
            end
         end
         for (int i = 0; i < 131; i++) begin
            send_request(pick_coordinate());
         end
         req_valid <= 1'b0;
      end
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
